>>> src/cll_pkg.sv
// package: constants, opcodes, status codes and control structs for the list engine
package cll_pkg;
    localparam int DEPTH = 256;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS = $clog2(DEPTH);
    localparam int PTR_BITS = SLOT_BITS + 1;
    localparam logic [PTR_BITS-1:0] NIL = PTR_BITS'(DEPTH);

    typedef logic [PTR_BITS-1:0] ptr_t;
    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [VALUE_BITS-1:0] val_t;

    typedef enum logic [3:0] {
        OP_PREPEND    = 4'd0,
        OP_APPEND     = 4'd1,
        OP_INS_BEFORE = 4'd2,
        OP_INS_AFTER  = 4'd3,
        OP_DEL_FRONT  = 4'd4,
        OP_DEL_BACK   = 4'd5,
        OP_DEL_CURSOR = 4'd6,
        OP_MV_FRONT   = 4'd7,
        OP_MV_BACK    = 4'd8,
        OP_MV_PREV    = 4'd9,
        OP_MV_NEXT    = 4'd10,
        OP_CLEAR      = 4'd11
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_NOCUR  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // latch the request
        logic read;     // phase 1: read neighbour links / free stack
        logic commit;   // phase 2: apply the operation
        logic fetch;    // phase 3: read front and back values
        logic finish;   // phase 4: register the result
    } cmd_t;
endpackage

>>> src/cll_if.sv
// valid/ready channel interfaces for requests and results
interface cll_req_if;
    import cll_pkg::*;
    logic valid;
    logic ready;
    logic [3:0] op;
    logic signed [31:0] value;
    modport source (output valid, output op, output value, input ready);
    modport sink (input valid, input op, input value, output ready);
endinterface

interface cll_rsp_if;
    logic valid;
    logic ready;
    logic [1:0] status;
    logic [8:0] count;
    logic signed [8:0] cursor_pos;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic signed [31:0] cursor_value;
    modport source (output valid, output status, output count, output cursor_pos,
                    output front_value, output back_value, output cursor_value, input ready);
    modport sink (input valid, input status, input count, input cursor_pos,
                  input front_value, input back_value, input cursor_value, output ready);
endinterface

>>> src/cll_ctrl.sv
// controller state machine sequencing the phases of one request
module cll_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output cll_pkg::cmd_t cmd
);
    import cll_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_COMMIT = 5'b00100,
        S_FETCH  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic finish;

    assign finish   = (state_reg == S_FINISH);
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid && in_ready) state_next = S_READ;
            S_READ:   state_next = S_COMMIT;
            S_COMMIT: state_next = S_FETCH;
            S_FETCH:  state_next = S_FINISH;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
        out_valid_next = out_valid_reg;
        if (out_ready) out_valid_next = 1'b0;
        if (finish) out_valid_next = 1'b1;
    end

    always_comb
    begin
        cmd.load   = in_valid && in_ready;
        cmd.read   = (state_reg == S_READ);
        cmd.commit = (state_reg == S_COMMIT);
        cmd.fetch  = (state_reg == S_FETCH);
        cmd.finish = finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

>>> src/cll_datapath.sv
// datapath: node memories, free stack, list registers and result register
module cll_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cll_pkg::cmd_t               cmd,
    input  logic [3:0]                  in_op,
    input  logic [cll_pkg::VALUE_BITS-1:0] in_value,
    output logic [1:0]                  status,
    output logic [8:0]                  count,
    output logic [8:0]                  cursor_pos,
    output logic [31:0]                 front_value,
    output logic [31:0]                 back_value,
    output logic [31:0]                 cursor_value
);
    import cll_pkg::*;

    val_t node_value [DEPTH];
    ptr_t node_next  [DEPTH];
    ptr_t node_prev  [DEPTH];
    slot_t free_stack [DEPTH];

    ptr_t free_top_reg, fresh_mark_reg, head_reg, tail_reg, cur_reg;
    logic [PTR_BITS-1:0] count_reg;
    logic [PTR_BITS:0] cidx_reg;     // signed, -1 undefined
    logic [3:0] op_reg;
    val_t val_reg;
    logic [1:0] st_reg;

    // phase 1 read data
    ptr_t cur_prev_reg, cur_next_reg, head_next_reg, tail_prev_reg;
    slot_t pop_slot_reg;

    // phase 3 read data
    val_t fv_reg, bv_reg;

    logic empty, nocur, full;
    assign empty = (count_reg == '0);
    assign nocur = cidx_reg[PTR_BITS] || (cur_reg == NIL);
    assign full  = (count_reg >= PTR_BITS'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_op;
            val_reg <= in_value;
        end
        if (cmd.read)
        begin
            cur_prev_reg  <= node_prev[cur_reg[SLOT_BITS-1:0]];
            cur_next_reg  <= node_next[cur_reg[SLOT_BITS-1:0]];
            head_next_reg <= node_next[head_reg[SLOT_BITS-1:0]];
            tail_prev_reg <= node_prev[tail_reg[SLOT_BITS-1:0]];
            pop_slot_reg  <= free_stack[SLOT_BITS'(free_top_reg - PTR_BITS'(1))];
        end
        if (cmd.fetch)
        begin
            fv_reg <= node_value[head_reg[SLOT_BITS-1:0]];
            bv_reg <= node_value[tail_reg[SLOT_BITS-1:0]];
        end
    end

    // commit decisions
    logic do_ins, do_del;
    ptr_t new_slot, del_slot, del_p, del_n, ins_p, ins_n;
    logic [1:0] st_c;

    always_comb
    begin
        st_c = ST_OK;
        do_ins = 1'b0;
        do_del = 1'b0;
        ins_p = NIL;
        ins_n = NIL;
        del_slot = NIL;
        del_p = NIL;
        del_n = NIL;
        case (op_reg)
            OP_PREPEND, OP_APPEND:
                if (full) st_c = ST_FULL; else do_ins = 1'b1;
            OP_INS_BEFORE, OP_INS_AFTER:
                if (empty) st_c = ST_EMPTY;
                else if (nocur) st_c = ST_NOCUR;
                else if (full) st_c = ST_FULL;
                else do_ins = 1'b1;
            OP_DEL_FRONT, OP_DEL_BACK:
                if (empty) st_c = ST_EMPTY; else do_del = 1'b1;
            OP_DEL_CURSOR:
                if (empty) st_c = ST_EMPTY;
                else if (nocur) st_c = ST_NOCUR;
                else do_del = 1'b1;
            OP_MV_FRONT, OP_MV_BACK:
                if (empty) st_c = ST_EMPTY;
            OP_MV_PREV, OP_MV_NEXT:
                if (empty) st_c = ST_EMPTY;
                else if (nocur) st_c = ST_NOCUR;
            default: st_c = ST_OK;
        endcase
        case (op_reg)
            OP_PREPEND:    begin ins_p = NIL; ins_n = head_reg; end
            OP_APPEND:     begin ins_p = tail_reg; ins_n = NIL; end
            OP_INS_BEFORE: begin ins_p = cur_prev_reg; ins_n = cur_reg; end
            OP_INS_AFTER:  begin ins_p = cur_reg; ins_n = cur_next_reg; end
            OP_DEL_FRONT:  begin del_slot = head_reg; del_p = NIL; del_n = head_next_reg; end
            OP_DEL_BACK:   begin del_slot = tail_reg; del_p = tail_prev_reg; del_n = NIL; end
            OP_DEL_CURSOR: begin del_slot = cur_reg; del_p = cur_prev_reg; del_n = cur_next_reg; end
            default:       ins_p = NIL;
        endcase
        new_slot = (free_top_reg != '0) ? {1'b0, pop_slot_reg} : fresh_mark_reg;
    end

    // memory writes: at most two link writes per memory in commit
    always_ff @(posedge clk)
    begin
        if (cmd.commit && do_ins)
        begin
            node_value[new_slot[SLOT_BITS-1:0]] <= val_reg;
            node_prev[new_slot[SLOT_BITS-1:0]]  <= ins_p;
            node_next[new_slot[SLOT_BITS-1:0]]  <= ins_n;
            if (ins_p != NIL) node_next[ins_p[SLOT_BITS-1:0]] <= new_slot;
            if (ins_n != NIL) node_prev[ins_n[SLOT_BITS-1:0]] <= new_slot;
        end
        if (cmd.commit && do_del)
        begin
            if (del_p != NIL) node_next[del_p[SLOT_BITS-1:0]] <= del_n;
            if (del_n != NIL) node_prev[del_n[SLOT_BITS-1:0]] <= del_p;
            free_stack[free_top_reg[SLOT_BITS-1:0]] <= del_slot[SLOT_BITS-1:0];
        end
    end

    logic [PTR_BITS:0] minus_one;
    assign minus_one = '1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_top_reg   <= '0;
            fresh_mark_reg <= '0;
            head_reg       <= NIL;
            tail_reg       <= NIL;
            cur_reg        <= NIL;
            count_reg      <= '0;
            cidx_reg       <= minus_one;
            st_reg         <= ST_OK;
        end
        else if (cmd.commit)
        begin
            st_reg <= st_c;
            if (do_ins)
            begin
                count_reg <= count_reg + PTR_BITS'(1);
                if (free_top_reg != '0) free_top_reg <= free_top_reg - PTR_BITS'(1);
                else fresh_mark_reg <= fresh_mark_reg + PTR_BITS'(1);
                if (ins_p == NIL) head_reg <= new_slot;
                if (ins_n == NIL) tail_reg <= new_slot;
                if ((op_reg == OP_PREPEND && !nocur) || op_reg == OP_INS_BEFORE)
                    cidx_reg <= cidx_reg + (PTR_BITS+1)'(1);
            end
            else if (do_del)
            begin
                count_reg <= count_reg - PTR_BITS'(1);
                if (free_top_reg < PTR_BITS'(DEPTH)) free_top_reg <= free_top_reg + PTR_BITS'(1);
                if (del_p == NIL) head_reg <= del_n;
                if (del_n == NIL) tail_reg <= del_p;
                if (cur_reg == del_slot || op_reg == OP_DEL_CURSOR)
                begin
                    cur_reg  <= NIL;
                    cidx_reg <= minus_one;
                end
                else if (op_reg == OP_DEL_FRONT && !nocur)
                    cidx_reg <= cidx_reg - (PTR_BITS+1)'(1);
            end
            else if (st_c == ST_OK)
            begin
                case (op_reg)
                    OP_MV_FRONT:
                    begin
                        cur_reg  <= head_reg;
                        cidx_reg <= '0;
                    end
                    OP_MV_BACK:
                    begin
                        cur_reg  <= tail_reg;
                        cidx_reg <= {1'b0, count_reg} - (PTR_BITS+1)'(1);
                    end
                    OP_MV_PREV:
                        if (cidx_reg == '0)
                        begin
                            cur_reg  <= NIL;
                            cidx_reg <= minus_one;
                        end
                        else
                        begin
                            cur_reg  <= cur_prev_reg;
                            cidx_reg <= cidx_reg - (PTR_BITS+1)'(1);
                        end
                    OP_MV_NEXT:
                        if (cidx_reg >= {1'b0, count_reg} - (PTR_BITS+1)'(1))
                        begin
                            cur_reg  <= NIL;
                            cidx_reg <= minus_one;
                        end
                        else
                        begin
                            cur_reg  <= cur_next_reg;
                            cidx_reg <= cidx_reg + (PTR_BITS+1)'(1);
                        end
                    OP_CLEAR:
                    begin
                        free_top_reg   <= '0;
                        fresh_mark_reg <= '0;
                        head_reg       <= NIL;
                        tail_reg       <= NIL;
                        cur_reg        <= NIL;
                        count_reg      <= '0;
                        cidx_reg       <= minus_one;
                    end
                    default: ;
                endcase
            end
        end
    end

    // result register, cursor value read here
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status       <= st_reg;
            count        <= 9'(count_reg);
            cursor_pos   <= 9'(cidx_reg);
            front_value  <= (head_reg == NIL) ? '0 : 32'(signed'(fv_reg));
            back_value   <= (tail_reg == NIL) ? '0 : 32'(signed'(bv_reg));
            cursor_value <= (cidx_reg[PTR_BITS] || cur_reg == NIL) ? '0
                            : 32'(signed'(node_value[cur_reg[SLOT_BITS-1:0]]));
        end
    end
endmodule

>>> src/cursor_linked_list_engine.sv
// top level of the cursor linked list engine
// Bounded doubly linked list of signed 32-bit values with one cursor.
// req channel: op and value, one list operation per request.
// rsp channel: status, count, cursor_pos, front, back and cursor values,
//   exactly one per request, in request order.
// Each request passes five steps: accept, link read, commit, front and back
//   value read, cursor value read; the result is registered in the last
//   step. The pace is set by the dependent node-memory reads and
//   writes of the relink and by two value reads a cycle.
// A new request is taken only after the previous one is through all steps, while the receiver keeps up.
// A finished result waits in the output register; a new request is taken
//   as soon as that register is free or being taken in the same cycle.
// While the receiver stalls, the result holds and no further request is
//   taken.
// Reset empties the list, returns every slot and makes the cursor undefined;
//   node memories are not cleared and need no clearing pass.
module cursor_linked_list_engine
(
    input logic        clk,
    input logic        rst_n,
    cll_req_if.sink    req,
    cll_rsp_if.source  rsp
);
    import cll_pkg::*;

    cmd_t cmd;

    cll_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    cll_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_op        (req.op),
        .in_value     (VALUE_BITS'(req.value)),
        .status       (rsp.status),
        .count        (rsp.count),
        .cursor_pos   (rsp.cursor_pos),
        .front_value  (rsp.front_value),
        .back_value   (rsp.back_value),
        .cursor_value (rsp.cursor_value)
    );
endmodule

>>> dv/cll_tb_pkg.sv
// scoreboard class with a list predictor for the cursor linked list engine
package cll_tb_pkg;
    import cll_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic [8:0]         count;
        logic signed [8:0]  cursor_pos;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic signed [31:0] cursor_value;
    } list_view_t;

    class list_scoreboard;
        logic signed [31:0] vals[$];
        int                 cur;
        list_view_t         pending[$];
        int                 errors;

        function new();
            vals.delete();
            cur = -1;
            errors = 0;
        endfunction

        function void note_request(logic [3:0] op, logic signed [31:0] value);
            list_view_t r;
            status_t st;
            int n;
            st = ST_OK;
            n = vals.size();
            case (op)
                OP_PREPEND:
                    if (n >= DEPTH) st = ST_FULL;
                    else
                    begin
                        vals.push_front(value);
                        if (cur >= 0) cur++;
                    end
                OP_APPEND:
                    if (n >= DEPTH) st = ST_FULL;
                    else vals.push_back(value);
                OP_INS_BEFORE, OP_INS_AFTER:
                    if (n == 0) st = ST_EMPTY;
                    else if (cur < 0) st = ST_NOCUR;
                    else if (n >= DEPTH) st = ST_FULL;
                    else if (op == OP_INS_BEFORE)
                    begin
                        vals.insert(cur, value);
                        cur++;
                    end
                    else vals.insert(cur + 1, value);
                OP_DEL_FRONT:
                    if (n == 0) st = ST_EMPTY;
                    else
                    begin
                        if (cur == 0) cur = -1;
                        else if (cur > 0) cur--;
                        vals.delete(0);
                    end
                OP_DEL_BACK:
                    if (n == 0) st = ST_EMPTY;
                    else
                    begin
                        if (cur == n - 1) cur = -1;
                        vals.delete(n - 1);
                    end
                OP_DEL_CURSOR:
                    if (n == 0) st = ST_EMPTY;
                    else if (cur < 0) st = ST_NOCUR;
                    else
                    begin
                        vals.delete(cur);
                        cur = -1;
                    end
                OP_MV_FRONT:
                    if (n == 0) st = ST_EMPTY;
                    else cur = 0;
                OP_MV_BACK:
                    if (n == 0) st = ST_EMPTY;
                    else cur = n - 1;
                OP_MV_PREV:
                    if (n == 0) st = ST_EMPTY;
                    else if (cur < 0) st = ST_NOCUR;
                    else cur = cur - 1;
                OP_MV_NEXT:
                    if (n == 0) st = ST_EMPTY;
                    else if (cur < 0) st = ST_NOCUR;
                    else if (cur >= n - 1) cur = -1;
                    else cur++;
                OP_CLEAR:
                begin
                    vals.delete();
                    cur = -1;
                end
                default: ;
            endcase
            n = vals.size();
            r.status = st;
            r.count = n[8:0];
            r.cursor_pos = cur[8:0];
            r.front_value = n ? vals[0] : 0;
            r.back_value = n ? vals[n - 1] : 0;
            r.cursor_value = cur >= 0 ? vals[cur] : 0;
            pending.push_back(r);
        endfunction

        function int size();
            return vals.size();
        endfunction

        function void report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endfunction

        function void check_result(list_view_t got);
            list_view_t e;
            if (pending.size() == 0)
            begin
                $display("mismatch: unexpected result");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) report("status", got.status, e.status);
            if (got.count !== e.count) report("count", got.count, e.count);
            if (got.cursor_pos !== e.cursor_pos)
                report("cursor_pos", got.cursor_pos, e.cursor_pos);
            if (got.front_value !== e.front_value)
                report("front_value", got.front_value, e.front_value);
            if (got.back_value !== e.back_value)
                report("back_value", got.back_value, e.back_value);
            if (got.cursor_value !== e.cursor_value)
                report("cursor_value", got.cursor_value, e.cursor_value);
        endfunction
    endclass
endpackage

>>> dv/tb_cursor_linked_list_engine.sv
// testbench top: drives list operations and checks every result
module tb_cursor_linked_list_engine;
    import cll_pkg::*;
    import cll_tb_pkg::*;

    logic clk;
    logic rst_n;
    bit   calm;
    bit   sent_all;
    list_scoreboard sb;

    cll_req_if req ();
    cll_rsp_if rsp ();

    cursor_linked_list_engine DUT (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(op_t op, logic signed [31:0] value);
        while (!calm && $urandom_range(0, 99) < 34)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.op <= op;
        req.value <= value;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_request(op, value);
        @(negedge clk);
    endtask

    // random operation biased toward inserts or deletes by the grow flag, which the caller sets from list length
    function automatic op_t pick_op(bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return OP_CLEAR;
        if (r < 45) return op_t'(grow ? $urandom_range(0, 3) : $urandom_range(4, 6));
        if (r < 55) return op_t'($urandom_range(0, 6));
        return op_t'($urandom_range(7, 10));
    endfunction

    initial
    begin
        bit grow;
        sb = new();
        rst_n = 1'b0;
        calm = 1'b0;
        sent_all = 1'b0;
        req.valid = 1'b0;
        req.op = '0;
        req.value = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // directed: empty-list errors, cursor errors, extremes
        send(OP_DEL_FRONT, 0);
        send(OP_DEL_BACK, 0);
        send(OP_DEL_CURSOR, 0);
        send(OP_MV_FRONT, 0);
        send(OP_MV_PREV, 0);
        send(OP_INS_BEFORE, 5);
        send(OP_APPEND, 32'sh7fffffff);
        send(OP_INS_AFTER, 1);
        send(OP_MV_NEXT, 0);
        send(OP_PREPEND, 32'sh80000000);
        send(OP_MV_FRONT, 0);
        send(OP_MV_PREV, 0);
        send(OP_MV_BACK, 0);
        send(OP_MV_NEXT, 0);
        send(OP_MV_BACK, 0);
        send(OP_INS_BEFORE, -1);
        send(OP_INS_AFTER, 0);
        send(OP_PREPEND, 7);
        send(OP_DEL_FRONT, 0);
        send(OP_MV_FRONT, 0);
        send(OP_DEL_FRONT, 0);
        send(OP_MV_BACK, 0);
        send(OP_DEL_BACK, 0);
        send(OP_DEL_CURSOR, 0);
        send(OP_CLEAR, 0);
        // fill to full once, hit the full case on every insert
        for (int i = 0; i < DEPTH; i++)
            send(OP_APPEND, rand_value());
        send(OP_MV_FRONT, 0);
        for (int i = 0; i < 4; i++)
            send(op_t'(i), rand_value());
        send(op_t'(12 + $urandom_range(0, 3)), rand_value());
        send(OP_CLEAR, 0);
        grow = 1'b1;
        for (int i = 0; i < 370; i++)
        begin
            calm = (i >= 150 && i < 230);
            if (sb.size() > 40) grow = 1'b0;
            if (sb.size() < 3) grow = 1'b1;
            if ($urandom_range(0, 199) == 0)
                send(op_t'($urandom_range(12, 15)), rand_value());
            else
                send(pick_op(grow), rand_value());
        end
        req.valid <= 1'b0;
        calm = 1'b0;
        sent_all = 1'b1;
    end

    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= calm || ($urandom_range(0, 99) >= 34);
        end
    end

    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result({rsp.status, rsp.count, rsp.cursor_pos,
                             rsp.front_value, rsp.back_value, rsp.cursor_value});

    initial
    begin
        wait (sent_all);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> filelist.f
src/cll_pkg.sv
src/cll_if.sv
src/cll_ctrl.sv
src/cll_datapath.sv
src/cursor_linked_list_engine.sv
dv/cll_tb_pkg.sv
dv/tb_cursor_linked_list_engine.sv
